### rtl/sqef_pkg.sv
// shared constants and scan state type for the shell quote escape filter
package sqef_pkg;

  localparam logic [7:0] CH_MARK   = 8'h01;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [4:0] {
    MODE_NORMAL = 5'b00001,
    MODE_DOLLAR = 5'b00010,
    MODE_BSLASH = 5'b00100,
    MODE_QUOTE  = 5'b01000,
    MODE_CLOSED = 5'b10000
  } mode_t;

  // up to two result bytes produced by one input item
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } res_t;

  function automatic res_t push_byte(res_t r, logic [7:0] b);
    res_t o;
    o = r;
    if (r.cnt == 2'd0) begin
      o.b0 = b;
    end else begin
      o.b1 = b;
    end
    o.cnt = r.cnt + 2'd1;
    return o;
  endfunction

endpackage

### rtl/shell_quote_escape_filter_top.sv
// shell quote escape filter: quote removal and backslash handling on a byte stream
//
// Takes one byte of a word per cycle while in_stall is low and removes quotes,
// a '$' in front of a quote, and backslashes outside quotes that escape a byte
// other than '$'; a 0x01 marker follows a closing quote when more bytes come.
// The first result of an item appears on the output in the cycle after the item
// is accepted. An item that yields two results (a held '$' or backslash flushed
// together with a byte, or a marker plus a byte) parks its second result in a
// one-entry overflow slot behind the output register, and in_stall stays high
// until that slot has drained. The word's last item always yields at least one
// result, flagged by last_out, carrying no byte if nothing is due.
module shell_quote_escape_filter_top
  import sqef_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] ch,
  input  logic       last_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       last_out
);

  mode_t      mode, mode_next;
  logic       dq, dq_next;
  logic       accept;
  logic       is_quote;
  res_t       res;

  logic       pend_v;
  logic [7:0] pend_byte;
  logic       pend_last;

  // output slot free now or being emptied this cycle
  assign in_stall = pend_v | (out_valid & out_stall);
  assign accept   = in_valid & ~in_stall;
  assign is_quote = (ch == CH_SQUOTE) || (ch == CH_DQUOTE);

  always_comb begin
    logic [7:0] q;
    logic       run_normal;
    res        = '0;
    mode_next  = mode;
    dq_next    = dq;
    run_normal = 1'b0;
    q          = dq ? CH_DQUOTE : CH_SQUOTE;

    case (mode)
      MODE_DOLLAR: begin
        if (is_quote) begin
          mode_next = MODE_QUOTE;
          dq_next   = (ch == CH_DQUOTE);
        end else begin
          res        = push_byte(res, CH_DOLLAR);
          run_normal = 1'b1;
        end
      end
      MODE_BSLASH: begin
        if (ch == CH_DOLLAR) begin
          res = push_byte(res, CH_BSLASH);
        end
        res       = push_byte(res, ch);
        mode_next = MODE_NORMAL;
      end
      MODE_QUOTE: begin
        if (ch == q) begin
          mode_next = MODE_CLOSED;
        end else begin
          res = push_byte(res, ch);
        end
      end
      MODE_CLOSED: begin
        res        = push_byte(res, CH_MARK);
        run_normal = 1'b1;
      end
      default: begin
        run_normal = 1'b1;
      end
    endcase

    if (run_normal) begin
      if (ch == CH_DOLLAR) begin
        mode_next = MODE_DOLLAR;
      end else if (is_quote) begin
        mode_next = MODE_QUOTE;
        dq_next   = (ch == CH_DQUOTE);
      end else if (ch == CH_BSLASH) begin
        mode_next = MODE_BSLASH;
      end else begin
        mode_next = MODE_NORMAL;
        res       = push_byte(res, ch);
      end
    end

    if (last_in) begin
      // flush a held prefix, then start the next word clean
      if (mode_next == MODE_DOLLAR) begin
        res = push_byte(res, CH_DOLLAR);
      end else if (mode_next == MODE_BSLASH) begin
        res = push_byte(res, CH_BSLASH);
      end
      mode_next = MODE_NORMAL;
      dq_next   = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_NORMAL;
      dq        <= 1'b0;
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      if (accept) begin
        mode      <= mode_next;
        dq        <= dq_next;
        out_valid <= (res.cnt != 2'd0) | last_in;
        pend_v    <= (res.cnt == 2'd2);
      end else if (!out_valid || !out_stall) begin
        out_valid <= pend_v;
        pend_v    <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte   <= (res.cnt == 2'd0) ? 8'h00 : res.b0;
      byte_valid <= (res.cnt != 2'd0);
      last_out   <= last_in & (res.cnt != 2'd2);
      pend_byte  <= res.b1;
      pend_last  <= last_in;
    end else if ((!out_valid || !out_stall) && pend_v) begin
      out_byte   <= pend_byte;
      byte_valid <= 1'b1;
      last_out   <= pend_last;
    end
  end

endmodule

### rtl/sqef_checker.sv
// port-level checks for the shell quote escape filter, bound to the top level
module sqef_port_checks (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] ch,
  input logic       last_in,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       last_out
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(byte_valid) && $stable(last_out))
    else $error("output item changed while stalled");

  // an empty result only closes a word
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last_out && out_byte == 8'h00)
    else $error("empty result without end of word");

  // the input side only waits on a busy output
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // the last byte of a word always yields a result next cycle
  a_last_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_in |=> out_valid)
    else $error("no result after end of word");

endmodule

bind shell_quote_escape_filter_top sqef_port_checks u_sqef_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .ch         (ch),
  .last_in    (last_in),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .byte_valid (byte_valid),
  .last_out   (last_out)
);
